/* hw/rtl/bcse_pkg.sv */
`default_nettype none

package bcse_pkg;

  localparam int unsigned DepthDefault = 64;

  // command codes carried in the mode field
  typedef enum logic [3:0] {
    M_PUSH_BACK  = 4'd0,
    M_PUSH_FRONT = 4'd1,
    M_INSERT_AT  = 4'd2,
    M_SORTED     = 4'd3,
    M_POP_FRONT  = 4'd4,
    M_POP_BACK   = 4'd5,
    M_REMOVE_AT  = 4'd6,
    M_REPLACE    = 4'd7,
    M_READ       = 4'd8,
    M_CLEAR      = 4'd9
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_UP_RD,
    S_UP_WR,
    S_SC_RD,
    S_SC_CMP,
    S_DN_RD,
    S_DN_WR,
    S_RD_CAP,
    S_FIN,
    S_F0,
    S_F1,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    RD_POS,
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_P1,
    RD_ZERO,
    RD_LAST
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_TGT_VAL,
    WR_IDX_DATA,
    WR_POS_VAL
  } wr_sel_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CNT,
    IDX_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic [2:0] {
    TGT_HOLD,
    TGT_CNT,
    TGT_ZERO,
    TGT_POS,
    TGT_IDX
  } tgt_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_e;

  // controller to datapath
  typedef struct packed {
    logic    cap_in;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    idx_op_e idx_op;
    tgt_op_e tgt_op;
    cnt_op_e cnt_op;
    logic    st_load;
    status_e st_val;
    logic    rdv_cap;
    logic    ends_clr;
    logic    first_cap;
    logic    last_cap;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [3:0] mode;
    logic       cnt_zero;
    logic       full;
    logic       pos_gt_cnt;
    logic       pos_ge_cnt;
    logic       idx_eq_tgt;
    logic       idx_eq_cnt;
    logic       idx_at_last;
    logic       val_le_data;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/bcse_dp.sv */
`default_nettype none

module bcse_dp #(
  parameter int unsigned DEPTH = bcse_pkg::DepthDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bcse_pkg::cmd_t cmd_i,
  output bcse_pkg::sts_t      sts_o,
  input  wire logic [3:0]     mode_i,
  input  wire logic [7:0]     char_value_i,
  input  wire logic [6:0]     position_i,
  output logic [7:0]          read_value_o,
  output logic [7:0]          first_value_o,
  output logic [7:0]          last_value_o,
  output logic [6:0]          item_count_o,
  output logic [1:0]          status_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > 7) ? CW : 7;

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] tgt_q, tgt_d;
  logic [3:0]    mode_q;
  logic [7:0]    val_q;
  logic [6:0]    pos_q;
  logic [7:0]    rdv_q, first_q, last_q;
  bcse_pkg::status_e st_q;

  logic [7:0]        rdv_out_q, first_out_q, last_out_q;
  logic [6:0]        cnt_out_q;
  bcse_pkg::status_e st_out_q;

  logic [CW-1:0]   idx_m1, idx_p1, cnt_m1;
  logic [CMPW-1:0] cnt_x, pos_x;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [7:0]      wr_data;

  assign idx_m1 = idx_q - CW'(1);
  assign idx_p1 = idx_q + CW'(1);
  assign cnt_m1 = cnt_q - CW'(1);
  assign cnt_x  = CMPW'(cnt_q);
  assign pos_x  = CMPW'(pos_q);

  always_comb begin
    case (cmd_i.rd_sel)
      bcse_pkg::RD_POS:    rd_addr = AW'(pos_q);
      bcse_pkg::RD_IDX:    rd_addr = idx_q[AW-1:0];
      bcse_pkg::RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
      bcse_pkg::RD_IDX_P1: rd_addr = idx_p1[AW-1:0];
      bcse_pkg::RD_LAST:   rd_addr = cnt_m1[AW-1:0];
      default:             rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      bcse_pkg::WR_TGT_VAL: begin
        wr_addr = tgt_q[AW-1:0];
        wr_data = val_q;
      end
      bcse_pkg::WR_IDX_DATA: begin
        wr_addr = idx_q[AW-1:0];
        wr_data = rdata_q;
      end
      default: begin
        wr_addr = AW'(pos_q);
        wr_data = val_q;
      end
    endcase
  end

  // byte store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    case (cmd_i.cnt_op)
      bcse_pkg::CNT_INC: cnt_d = cnt_q + CW'(1);
      bcse_pkg::CNT_DEC: cnt_d = cnt_m1;
      bcse_pkg::CNT_CLR: cnt_d = '0;
      default:           cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    case (cmd_i.idx_op)
      bcse_pkg::IDX_CNT:  idx_d = cnt_q;
      bcse_pkg::IDX_POS:  idx_d = CW'(pos_q);
      bcse_pkg::IDX_ZERO: idx_d = '0;
      bcse_pkg::IDX_INC:  idx_d = idx_p1;
      bcse_pkg::IDX_DEC:  idx_d = idx_m1;
      default:            idx_d = idx_q;
    endcase
  end

  always_comb begin
    case (cmd_i.tgt_op)
      bcse_pkg::TGT_CNT:  tgt_d = cnt_q;
      bcse_pkg::TGT_ZERO: tgt_d = '0;
      bcse_pkg::TGT_POS:  tgt_d = CW'(pos_q);
      bcse_pkg::TGT_IDX:  tgt_d = idx_q;
      default:            tgt_d = tgt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    tgt_q <= tgt_d;
    if (cmd_i.cap_in) begin
      mode_q <= mode_i;
      val_q  <= char_value_i;
      pos_q  <= position_i;
      rdv_q  <= '0;
      st_q   <= bcse_pkg::ST_OK;
    end else begin
      if (cmd_i.st_load) begin
        st_q <= cmd_i.st_val;
      end
      if (cmd_i.rdv_cap) begin
        rdv_q <= rdata_q;
      end
    end
    if (cmd_i.ends_clr) begin
      first_q <= '0;
      last_q  <= '0;
    end else begin
      if (cmd_i.first_cap) begin
        first_q <= rdata_q;
      end
      if (cmd_i.last_cap) begin
        last_q <= rdata_q;
      end
    end
    if (cmd_i.out_load) begin
      rdv_out_q   <= rdv_q;
      first_out_q <= first_q;
      last_out_q  <= last_q;
      cnt_out_q   <= 7'(cnt_q);
      st_out_q    <= st_q;
    end
  end

  assign sts_o.mode        = mode_q;
  assign sts_o.cnt_zero    = (cnt_q == '0);
  assign sts_o.full        = (cnt_q == CW'(DEPTH));
  assign sts_o.pos_gt_cnt  = (pos_x > cnt_x);
  assign sts_o.pos_ge_cnt  = (pos_x >= cnt_x);
  assign sts_o.idx_eq_tgt  = (idx_q == tgt_q);
  assign sts_o.idx_eq_cnt  = (idx_q == cnt_q);
  assign sts_o.idx_at_last = (idx_q == cnt_m1);
  assign sts_o.val_le_data = (val_q <= rdata_q);

  assign read_value_o  = rdv_out_q;
  assign first_value_o = first_out_q;
  assign last_value_o  = last_out_q;
  assign item_count_o  = cnt_out_q;
  assign status_o      = st_out_q;

endmodule

`default_nettype wire

/* hw/rtl/bcse_ctrl.sv */
`default_nettype none

module bcse_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire bcse_pkg::sts_t sts_i,
  output bcse_pkg::cmd_t      cmd_o
);

  bcse_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcse_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;

    case (state_q)
      bcse_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = bcse_pkg::S_EXEC;
        end
      end

      bcse_pkg::S_EXEC: begin
        state_d = bcse_pkg::S_FIN;
        case (sts_i.mode)
          bcse_pkg::M_PUSH_BACK, bcse_pkg::M_PUSH_FRONT: begin
            if (sts_i.full) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_val  = bcse_pkg::ST_FULL;
            end else begin
              cmd_o.idx_op = bcse_pkg::IDX_CNT;
              cmd_o.tgt_op = (sts_i.mode == bcse_pkg::M_PUSH_BACK) ?
                             bcse_pkg::TGT_CNT : bcse_pkg::TGT_ZERO;
              state_d      = bcse_pkg::S_UP_RD;
            end
          end
          bcse_pkg::M_INSERT_AT: begin
            if (sts_i.pos_gt_cnt) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_val  = bcse_pkg::ST_RANGE;
            end else if (sts_i.full) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_val  = bcse_pkg::ST_FULL;
            end else begin
              cmd_o.idx_op = bcse_pkg::IDX_CNT;
              cmd_o.tgt_op = bcse_pkg::TGT_POS;
              state_d      = bcse_pkg::S_UP_RD;
            end
          end
          bcse_pkg::M_SORTED: begin
            if (sts_i.full) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_val  = bcse_pkg::ST_FULL;
            end else begin
              cmd_o.idx_op = bcse_pkg::IDX_ZERO;
              state_d      = bcse_pkg::S_SC_RD;
            end
          end
          bcse_pkg::M_POP_FRONT: begin
            if (sts_i.cnt_zero) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_val  = bcse_pkg::ST_EMPTY;
            end else begin
              cmd_o.idx_op = bcse_pkg::IDX_ZERO;
              state_d      = bcse_pkg::S_DN_RD;
            end
          end
          bcse_pkg::M_POP_BACK: begin
            if (sts_i.cnt_zero) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_val  = bcse_pkg::ST_EMPTY;
            end else begin
              cmd_o.cnt_op = bcse_pkg::CNT_DEC;
            end
          end
          bcse_pkg::M_REMOVE_AT: begin
            if (sts_i.pos_ge_cnt) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_val  = bcse_pkg::ST_RANGE;
            end else begin
              cmd_o.idx_op = bcse_pkg::IDX_POS;
              state_d      = bcse_pkg::S_DN_RD;
            end
          end
          bcse_pkg::M_REPLACE: begin
            if (sts_i.pos_ge_cnt) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_val  = bcse_pkg::ST_RANGE;
            end else begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wr_sel = bcse_pkg::WR_POS_VAL;
            end
          end
          bcse_pkg::M_READ: begin
            if (sts_i.pos_ge_cnt) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_val  = bcse_pkg::ST_RANGE;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = bcse_pkg::RD_POS;
              state_d      = bcse_pkg::S_RD_CAP;
            end
          end
          bcse_pkg::M_CLEAR: begin
            cmd_o.cnt_op = bcse_pkg::CNT_CLR;
          end
          default: begin
          end
        endcase
      end

      // open a gap: walk down from the count to the target
      bcse_pkg::S_UP_RD: begin
        if (sts_i.idx_eq_tgt) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = bcse_pkg::WR_TGT_VAL;
          cmd_o.cnt_op = bcse_pkg::CNT_INC;
          state_d      = bcse_pkg::S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = bcse_pkg::RD_IDX_M1;
          state_d      = bcse_pkg::S_UP_WR;
        end
      end

      bcse_pkg::S_UP_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = bcse_pkg::WR_IDX_DATA;
        cmd_o.idx_op = bcse_pkg::IDX_DEC;
        state_d      = bcse_pkg::S_UP_RD;
      end

      // search for the first stored byte not below the new one
      bcse_pkg::S_SC_RD: begin
        if (sts_i.idx_eq_cnt) begin
          cmd_o.tgt_op = bcse_pkg::TGT_IDX;
          state_d      = bcse_pkg::S_UP_RD;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = bcse_pkg::RD_IDX;
          state_d      = bcse_pkg::S_SC_CMP;
        end
      end

      bcse_pkg::S_SC_CMP: begin
        if (sts_i.val_le_data) begin
          cmd_o.tgt_op = bcse_pkg::TGT_IDX;
          cmd_o.idx_op = bcse_pkg::IDX_CNT;
          state_d      = bcse_pkg::S_UP_RD;
        end else begin
          cmd_o.idx_op = bcse_pkg::IDX_INC;
          state_d      = bcse_pkg::S_SC_RD;
        end
      end

      // close a gap: walk up from the index to the back
      bcse_pkg::S_DN_RD: begin
        if (sts_i.idx_at_last) begin
          cmd_o.cnt_op = bcse_pkg::CNT_DEC;
          state_d      = bcse_pkg::S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = bcse_pkg::RD_IDX_P1;
          state_d      = bcse_pkg::S_DN_WR;
        end
      end

      bcse_pkg::S_DN_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = bcse_pkg::WR_IDX_DATA;
        cmd_o.idx_op = bcse_pkg::IDX_INC;
        state_d      = bcse_pkg::S_DN_RD;
      end

      bcse_pkg::S_RD_CAP: begin
        cmd_o.rdv_cap = 1'b1;
        state_d       = bcse_pkg::S_FIN;
      end

      // fetch front and back bytes for the result, or clear them when the list is empty
      bcse_pkg::S_FIN: begin
        if (sts_i.cnt_zero) begin
          cmd_o.ends_clr = 1'b1;
          state_d        = bcse_pkg::S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = bcse_pkg::RD_ZERO;
          state_d      = bcse_pkg::S_F0;
        end
      end

      bcse_pkg::S_F0: begin
        cmd_o.first_cap = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = bcse_pkg::RD_LAST;
        state_d         = bcse_pkg::S_F1;
      end

      bcse_pkg::S_F1: begin
        cmd_o.last_cap = 1'b1;
        state_d        = bcse_pkg::S_DONE;
      end

      bcse_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = bcse_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bcse_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/bounded_char_sequence_engine_top.sv */
// Bounded byte sequence engine: keeps an ordered list of up to DEPTH bytes in a
// single-port-read memory and runs one command per input transaction (push back
// or front, insert at an index, sorted insert, pop front or back, remove at an
// index, replace, read, clear). Each command returns one result transaction with
// the byte read, the front and back bytes, the count and a status (ok, index out
// of range, empty, full); on any error the list is left unchanged. Commands are
// handled one at a time by a sequencer that moves one entry at a time, a read
// then a write, through the memory's read port. Inserts move the entries behind
// the insert point, removes and pop front the entries after it, and a sorted
// insert first examines the stored entries in order until it finds its place or
// reaches the back. The next input is taken in the cycle after the result is
// loaded into the output register, which frees as soon as the previous result
// has been taken. Memory contents need no clearing after reset: entries at or
// beyond the count are never read.

`default_nettype none

module bounded_char_sequence_engine_top #(
  parameter int unsigned DEPTH = bcse_pkg::DepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,

  // command transaction
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [3:0] mode_i,
  input  wire logic [7:0] char_value_i,
  input  wire logic [6:0] position_i,

  // result transaction
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      read_value_o,
  output logic [7:0]      first_value_o,
  output logic [7:0]      last_value_o,
  output logic [6:0]      item_count_o,
  output logic [1:0]      status_o
);

  // command bundle from sequencer, status bundle back from datapath
  bcse_pkg::cmd_t cmd;
  bcse_pkg::sts_t sts;

  // sequencer: decodes the command and steps the shift and search walks
  bcse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: byte store, count, walk index, and result registers
  bcse_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (mode_i),
    .char_value_i  (char_value_i),
    .position_i    (position_i),
    .read_value_o  (read_value_o),
    .first_value_o (first_value_o),
    .last_value_o  (last_value_o),
    .item_count_o  (item_count_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire
